// ===== sv/lc3s_pkg.sv =====
// Shared constants, types and helper functions of the LC-3 subset core.
package lc3s_pkg;

   // Program memory depth, a power of two from 16 to 65536
   localparam int unsigned MEM_DEPTH   = 64;
   localparam int unsigned ADDR_W      = $clog2(MEM_DEPTH);
   localparam int unsigned WORD_W      = 16;
   localparam int unsigned REG_COUNT   = 8;
   localparam int unsigned REG_IDX_W   = $clog2(REG_COUNT);
   localparam int unsigned LOAD_ADDR_W = 6;
   localparam int unsigned PC_OUT_W    = 6;
   localparam int unsigned CC_W        = 3;
   localparam int unsigned OPC_W       = 4;
   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned OFF9_W      = 9;
   localparam int unsigned IMM5_W      = 5;
   localparam int unsigned VEC_W       = 8;

   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [WORD_W-1:0]      word_type;
   typedef logic [REG_IDX_W-1:0]   reg_idx_type;
   typedef logic [LOAD_ADDR_W-1:0] load_addr_type;
   typedef logic [PC_OUT_W-1:0]    pc_out_type;
   typedef logic [CC_W-1:0]        cc_type;
   typedef logic [OPC_W-1:0]       opcode_type;
   typedef logic [CHAR_W-1:0]      char_type;
   typedef logic [OFF9_W-1:0]      off9_type;
   typedef logic [IMM5_W-1:0]      imm5_type;
   typedef logic [VEC_W-1:0]       vec_type;

   // Item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   // Opcodes
   localparam opcode_type OP_BR   = 4'd0;
   localparam opcode_type OP_ADD  = 4'd1;
   localparam opcode_type OP_LD   = 4'd2;
   localparam opcode_type OP_NOT  = 4'd9;
   localparam opcode_type OP_TRAP = 4'd15;

   // Trap vectors
   localparam vec_type TRAP_OUT  = 8'h21;
   localparam vec_type TRAP_HALT = 8'h25;

   // Condition codes
   localparam cc_type CC_NEG  = 3'b100;
   localparam cc_type CC_ZERO = 3'b010;
   localparam cc_type CC_POS  = 3'b001;

   // Result source of a register write
   typedef enum logic [1:0] {
      SEL_NOT,
      SEL_ADD,
      SEL_LD
   } alu_sel_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      word_type data;
   } mem_wr_type;

   typedef struct packed {
      logic        en;
      reg_idx_type idx;
      word_type    data;
   } rf_wr_type;

   typedef struct packed {
      pc_out_type  pc_value;
      cc_type      cc_flags;
      logic        reg_written;
      reg_idx_type dest_index;
      word_type    dest_value;
      logic        out_valid;
      char_type    out_char;
      logic        halted;
      opcode_type  executed_opcode;
   } rsp_word_type;

   // Condition codes of a written value
   function automatic cc_type cc_of(input word_type value);
      cc_type cc;
      if (value[WORD_W-1]) begin
         cc = CC_NEG;
      end else if (value == '0) begin
         cc = CC_ZERO;
      end else begin
         cc = CC_POS;
      end
      return cc;
   endfunction

   // Low bits of the pc as reported
   function automatic pc_out_type pc_report(input addr_type pc);
      logic [31:0] wide;
      wide = 32'(pc);
      return wide[PC_OUT_W-1:0];
   endfunction

   // Load address wrapped to the memory depth
   function automatic addr_type load_addr(input load_addr_type la);
      logic [31:0] wide;
      wide = 32'(la);
      return wide[ADDR_W-1:0];
   endfunction

   // pc plus sign-extended 9-bit offset, wrapped to the memory depth
   function automatic addr_type rel_addr(input addr_type pc, input off9_type off);
      logic [31:0] soff;
      logic [31:0] sum;
      soff = {{(32-OFF9_W){off[OFF9_W-1]}}, off};
      sum  = 32'(pc) + soff;
      return sum[ADDR_W-1:0];
   endfunction

endpackage

// ===== sv/lc3s_ifs.sv =====
// Request and response channel interfaces of the LC-3 subset core.
interface lc3s_req_if;
   import lc3s_pkg::*;

   logic          valid;
   logic          ready;
   logic          kind;
   load_addr_type load_address;
   word_type      load_data;

   modport source (output valid, kind, load_address, load_data, input ready);
   modport sink   (input valid, kind, load_address, load_data, output ready);
endinterface

interface lc3s_rsp_if;
   import lc3s_pkg::*;

   logic        valid;
   logic        ready;
   pc_out_type  pc_value;
   cc_type      cc_flags;
   logic        reg_written;
   reg_idx_type dest_index;
   word_type    dest_value;
   logic        out_valid;
   char_type    out_char;
   logic        halted;
   opcode_type  executed_opcode;

   modport source (output valid, pc_value, cc_flags, reg_written, dest_index, dest_value,
                   out_valid, out_char, halted, executed_opcode, input ready);
   modport sink   (input valid, pc_value, cc_flags, reg_written, dest_index, dest_value,
                   out_valid, out_char, halted, executed_opcode, output ready);
endinterface

// ===== sv/lc3_subset_core_step.sv =====
// Top level of the LC-3 subset core: fetch, decode and execute around two memories.
//
//   channel   dir  handshake            payload
//   req_chan  in   valid/ready          kind, load_address, load_data
//   rsp_chan  out  valid/ready          pc_value .. executed_opcode
//
// An item passes from acceptance to its response word through fetch (program
// memory read at pc, or the load write), decode (second read for LD, pc and halt
// update, register reads) and execute (register write, condition codes, response).
// No new item is taken while the last one is in decode; the single program memory
// read port, used by fetch and then by LD, is the reason.
// Synchronous reset clears pc, condition codes, halt flag, the valid bits of both
// memories and the response queue; no clearing pass is needed.
// A stalled response channel fills the two-entry queue; requests are then held off.
module lc3_subset_core_step (
   input  logic       clock,
   input  logic       reset,
   lc3s_req_if.sink   req_chan,
   lc3s_rsp_if.source rsp_chan
);
   import lc3s_pkg::*;

   // Architectural state
   addr_type     pc_ff, pc_in;
   cc_type       cc_ff, cc_in;
   logic         halt_ff, halt_in;
   logic [1:0]   cnt_ff, cnt_in;

   // Decode stage
   logic         b_vld_ff;
   logic         b_kind_ff;

   // Execute stage
   logic         c_vld_ff;
   logic         c_wr_ff, c_wr_in;
   logic         c_out_ff, c_out_in;
   opcode_type   c_op_ff, c_op_in;
   alu_sel_type  c_sel_ff, c_sel_in;
   reg_idx_type  c_dr_ff;
   logic         c_imm_ff;
   imm5_type     c_imm5_ff;

   logic         acc;
   logic         dlv;
   word_type     mem_rdata;
   word_type     ir;
   opcode_type   op;
   logic         exec;
   addr_type     pc_plus;
   addr_type     rel_tgt;
   logic         taken;
   addr_type     mem_raddr;
   reg_idx_type  rf_raddr_b;
   mem_wr_type   mem_wr;
   rf_wr_type    rf_wr;
   word_type     rs1;
   word_type     rs2;
   word_type     operand;
   word_type     result;
   rsp_word_type rsp_word;

   assign acc = req_chan.valid && req_chan.ready;
   assign dlv = rsp_chan.valid && rsp_chan.ready;

   // Take a word when decode is free and the queue has room for it
   assign req_chan.ready = !b_vld_ff && (cnt_ff != 2'd2);

   // Write a load word into program memory on acceptance
   always_comb begin
      mem_wr.en   = acc && (req_chan.kind == KIND_LOAD);
      mem_wr.addr = load_addr(req_chan.load_address);
      mem_wr.data = req_chan.load_data;
   end

   // Decode the fetched instruction
   assign ir      = mem_rdata;
   assign op      = ir[15:12];
   assign exec    = b_vld_ff && (b_kind_ff == KIND_STEP) && !halt_ff;
   assign pc_plus = pc_ff + addr_type'(1);
   assign rel_tgt = rel_addr(pc_plus, ir[8:0]);
   assign taken   = (op == OP_BR) && ((ir[11:9] & cc_ff) != '0);

   // Fetch at pc, or read the LD operand during decode
   assign mem_raddr  = b_vld_ff ? rel_tgt : pc_ff;
   assign rf_raddr_b = (op == OP_TRAP) ? '0 : ir[2:0];

   lc3s_pmem u_pmem (
      .clock (clock),
      .reset (reset),
      .wr    (mem_wr),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Work out the decode-stage controls
   always_comb begin
      pc_in    = exec ? (taken ? rel_tgt : pc_plus) : pc_ff;
      halt_in  = halt_ff || (exec && (op == OP_TRAP) && (ir[7:0] == TRAP_HALT));
      c_wr_in  = exec && ((op == OP_NOT) || (op == OP_ADD) || (op == OP_LD));
      c_out_in = exec && (op == OP_TRAP) && (ir[7:0] == TRAP_OUT);
      c_op_in  = exec ? op : '0;
      priority if (op == OP_NOT) begin
         c_sel_in = SEL_NOT;
      end else if (op == OP_ADD) begin
         c_sel_in = SEL_ADD;
      end else begin
         c_sel_in = SEL_LD;
      end
   end

   lc3s_rf u_rf (
      .clock   (clock),
      .reset   (reset),
      .wr      (rf_wr),
      .raddr_a (ir[8:6]),
      .raddr_b (rf_raddr_b),
      .rdata_a (rs1),
      .rdata_b (rs2)
   );

   // Execute: form the written value
   assign operand = c_imm_ff ? {{(WORD_W-IMM5_W){c_imm5_ff[IMM5_W-1]}}, c_imm5_ff} : rs2;

   always_comb begin
      unique case (c_sel_ff)
         SEL_NOT: result = ~rs1;
         SEL_ADD: result = rs1 + operand;
         SEL_LD:  result = mem_rdata;
         default: result = mem_rdata;
      endcase
   end

   // Write back and update condition codes
   always_comb begin
      rf_wr.en   = c_vld_ff && c_wr_ff;
      rf_wr.idx  = c_dr_ff;
      rf_wr.data = result;
      cc_in      = rf_wr.en ? cc_of(result) : cc_ff;
   end

   // Build the response word
   always_comb begin
      rsp_word.pc_value        = pc_report(pc_ff);
      rsp_word.cc_flags        = cc_in;
      rsp_word.reg_written     = c_wr_ff;
      rsp_word.dest_index      = c_wr_ff ? c_dr_ff : '0;
      rsp_word.dest_value      = c_wr_ff ? result : '0;
      rsp_word.out_valid       = c_out_ff;
      rsp_word.out_char        = c_out_ff ? rs2[CHAR_W-1:0] : '0;
      rsp_word.halted          = halt_ff;
      rsp_word.executed_opcode = c_op_ff;
   end

   lc3s_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (c_vld_ff),
      .push_word (rsp_word),
      .rsp_chan  (rsp_chan)
   );

   // Count words accepted but not yet delivered
   assign cnt_in = cnt_ff + 2'(acc) - 2'(dlv);

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         cc_ff    <= '0;
         halt_ff  <= 1'b0;
         cnt_ff   <= 2'd0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         b_vld_ff <= acc;
         c_vld_ff <= b_vld_ff;
         if (b_vld_ff) begin
            pc_ff   <= pc_in;
            halt_ff <= halt_in;
         end
         cc_ff <= cc_in;
      end
   end

   // Hold stage payload
   always_ff @(posedge clock) begin
      if (acc) begin
         b_kind_ff <= req_chan.kind;
      end
      if (b_vld_ff) begin
         c_wr_ff   <= c_wr_in;
         c_out_ff  <= c_out_in;
         c_op_ff   <= c_op_in;
         c_sel_ff  <= c_sel_in;
         c_dr_ff   <= ir[11:9];
         c_imm_ff  <= ir[5];
         c_imm5_ff <= ir[4:0];
      end
   end

endmodule

// ===== sv/lc3s_pmem.sv =====
// Program memory: one write port, one registered read port, per-entry valid bits.
module lc3s_pmem (
   input  logic                 clock,
   input  logic                 reset,
   input  lc3s_pkg::mem_wr_type wr,
   input  lc3s_pkg::addr_type   raddr,
   output lc3s_pkg::word_type   rdata
);
   import lc3s_pkg::*;

   word_type             mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] valid_ff;
   word_type             rdata_ff;
   logic                 rvalid_ff;

   // Write and read the array; the read returns the old word on a clash
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rdata_ff <= mem_ff[raddr];
   end

   // Track written entries; unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= valid_ff[raddr];
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
      end
   end

   assign rdata = rvalid_ff ? rdata_ff : '0;

endmodule

// ===== sv/lc3s_rf.sv =====
// Register file: two registered read ports, one write port, reset value is the index.
module lc3s_rf (
   input  logic                  clock,
   input  logic                  reset,
   input  lc3s_pkg::rf_wr_type   wr,
   input  lc3s_pkg::reg_idx_type raddr_a,
   input  lc3s_pkg::reg_idx_type raddr_b,
   output lc3s_pkg::word_type    rdata_a,
   output lc3s_pkg::word_type    rdata_b
);
   import lc3s_pkg::*;

   word_type             regs_ff [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   word_type             data_a_ff;
   word_type             data_b_ff;
   reg_idx_type          idx_a_ff;
   reg_idx_type          idx_b_ff;
   logic                 vld_a_ff;
   logic                 vld_b_ff;

   // Write and read the array
   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_ff[wr.idx] <= wr.data;
      end
      data_a_ff <= regs_ff[raddr_a];
      data_b_ff <= regs_ff[raddr_b];
      idx_a_ff  <= raddr_a;
      idx_b_ff  <= raddr_b;
   end

   // Track written registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_a_ff <= valid_ff[raddr_a];
         vld_b_ff <= valid_ff[raddr_b];
         if (wr.en) begin
            valid_ff[wr.idx] <= 1'b1;
         end
      end
   end

   // Unwritten registers read as their own index
   assign rdata_a = vld_a_ff ? data_a_ff : WORD_W'(idx_a_ff);
   assign rdata_b = vld_b_ff ? data_b_ff : WORD_W'(idx_b_ff);

endmodule

// ===== sv/lc3s_outq.sv =====
// Two-entry response queue that drives the response channel.
module lc3s_outq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lc3s_pkg::rsp_word_type push_word,
   lc3s_rsp_if.source             rsp_chan
);
   import lc3s_pkg::*;

   rsp_word_type slot_ff [2];
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic [1:0]   fill_ff;
   logic         pop;
   rsp_word_type head;

   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign head = slot_ff[rd_ptr_ff];

   // Store pushed words
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

   // Present the head word
   always_comb begin
      rsp_chan.valid           = (fill_ff != 2'd0);
      rsp_chan.pc_value        = head.pc_value;
      rsp_chan.cc_flags        = head.cc_flags;
      rsp_chan.reg_written     = head.reg_written;
      rsp_chan.dest_index      = head.dest_index;
      rsp_chan.dest_value      = head.dest_value;
      rsp_chan.out_valid       = head.out_valid;
      rsp_chan.out_char        = head.out_char;
      rsp_chan.halted          = head.halted;
      rsp_chan.executed_opcode = head.executed_opcode;
   end

endmodule

// ===== sv/lc3s_checker.sv =====
// Port checker for the LC-3 subset core, bound to the top level.
module lc3s_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input lc3s_pkg::pc_out_type rsp_pc_value,
   input lc3s_pkg::word_type   rsp_dest_value,
   input logic                 rsp_reg_written,
   input logic                 rsp_out_valid,
   input logic                 rsp_halted,
   input lc3s_pkg::opcode_type rsp_executed_opcode
);
   import lc3s_pkg::*;

   logic [2:0] outst_ff;
   logic       seen_halt_ff;
   logic       acc;
   logic       dlv;

   assign acc = req_valid && req_ready;
   assign dlv = rsp_valid && rsp_ready;

   // Track outstanding words and a delivered halt
   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff     <= '0;
         seen_halt_ff <= 1'b0;
      end else begin
         outst_ff <= outst_ff + 3'(acc) - 3'(dlv);
         if (dlv && rsp_halted) begin
            seen_halt_ff <= 1'b1;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pc_value)
         && $stable(rsp_dest_value) && $stable(rsp_executed_opcode))
      else $error("response word changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outst_ff != 3'd0)
      else $error("response word without an outstanding request");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_halt_ff |-> rsp_halted)
      else $error("halt flag dropped without reset");

   a_out_is_trap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_executed_opcode == OP_TRAP && !rsp_reg_written)
      else $error("character output from a non-trap instruction");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind lc3_subset_core_step lc3s_checker u_lc3s_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_pc_value        (rsp_chan.pc_value),
   .rsp_dest_value      (rsp_chan.dest_value),
   .rsp_reg_written     (rsp_chan.reg_written),
   .rsp_out_valid       (rsp_chan.out_valid),
   .rsp_halted          (rsp_chan.halted),
   .rsp_executed_opcode (rsp_chan.executed_opcode)
);
